/* hdl/ula_pkg.sv */
// ----------------------------------------------------------------------------
// ULA pixel generator package
// Field widths, input and register codes, screen mode codes and the command
// format that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package ula_pkg;

    // Storage sizes.
    localparam int ULA_VRAM_DEPTH  = 16384;
    localparam int ULA_QUEUE_DEPTH = 2;

    // Field widths of the channels.
    localparam int KIND_W     = 2;
    localparam int ADDR_W     = 14;
    localparam int DATA_W     = 8;
    localparam int ROW_W      = 8;
    localparam int GROUP_W    = 6;
    localparam int BORDER_W   = 3;
    localparam int PIXEL_W    = 32;
    localparam int COLOUR_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RENDER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FRAME  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FINE_SCROLL_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TMX_BORDER    = 3'd4;

    // Screen mode codes (port bits 5:3).
    localparam logic [2:0] SCR_STD      = 3'd0;
    localparam logic [2:0] SCR_STD_ALT  = 3'd1;
    localparam logic [2:0] SCR_HICOL_0  = 3'd2;
    localparam logic [2:0] SCR_HICOL_1  = 3'd3;
    localparam logic [2:0] SCR_STD_4    = 3'd4;
    localparam logic [2:0] SCR_STD_5    = 3'd5;
    localparam logic [2:0] SCR_HIRES_0  = 3'd6;
    localparam logic [2:0] SCR_HIRES_1  = 3'd7;

    // Frame geometry.
    localparam logic [ROW_W-1:0]   ROW_DISP_FIRST   = 8'd32;
    localparam logic [ROW_W-1:0]   ROW_DISP_END     = 8'd224;
    localparam logic [GROUP_W-1:0] GROUP_DISP_FIRST = 6'd4;
    localparam logic [GROUP_W-1:0] GROUP_DISP_END   = 6'd36;

    // Back end operations.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FRAME = 2'd1,
        OP_FILL  = 2'd2,
        OP_DISP  = 2'd3
    } t_op;

    // Colour source of a display group.
    typedef enum logic {
        DM_ATTR  = 1'b0,
        DM_HIRES = 1'b1
    } t_dmode;

    // One classified item. A display group reads the pixel and attribute
    // bytes at addr0/addr1 first, then at addr2/addr3.
    typedef struct packed {
        t_op                 op;
        t_dmode              dmode;
        logic [ADDR_W-1:0]   addr0;
        logic [ADDR_W-1:0]   addr1;
        logic [ADDR_W-1:0]   addr2;
        logic [ADDR_W-1:0]   addr3;
        logic [DATA_W-1:0]   wdata;
        logic [2:0]          shift;
        logic [COLOUR_W-1:0] colour;
        logic [2:0]          ink;
        logic [2:0]          paper;
    } t_cmd;

endpackage

/* hdl/ula_in_if.sv */
// ----------------------------------------------------------------------------
// ULA input channel
// Valid/ready channel that carries one video RAM write, render or frame end.
// ----------------------------------------------------------------------------
interface ula_in_if import ula_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   vram_addr;
    logic [DATA_W-1:0]   vram_data;
    logic [ROW_W-1:0]    fb_row;
    logic [GROUP_W-1:0]  fb_group;
    logic [BORDER_W-1:0] border_colour;

    modport source (
        output valid, kind, vram_addr, vram_data, fb_row, fb_group, border_colour,
        input  ready
    );
    modport sink (
        input  valid, kind, vram_addr, vram_data, fb_row, fb_group, border_colour,
        output ready
    );
endinterface

/* hdl/ula_out_if.sv */
// ----------------------------------------------------------------------------
// ULA output channel
// Valid/ready channel that carries one group of eight colour indices.
// ----------------------------------------------------------------------------
interface ula_out_if import ula_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_group;

    modport source (
        output valid, pixel_group,
        input  ready
    );
    modport sink (
        input  valid, pixel_group,
        output ready
    );
endinterface

/* hdl/ula_cfg_if.sv */
// ----------------------------------------------------------------------------
// ULA configuration channel
// Valid/ready write channel that carries a register index and its data.
// ----------------------------------------------------------------------------
interface ula_cfg_if import ula_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* hdl/ula_video_pixel_generator.sv */
// ----------------------------------------------------------------------------
// ULA video pixel generator
// Spectrum/Timex style pixel generator: 16 KiB video RAM, four screen modes,
// border, scroll and flash, eight 4-bit colour indices per render item.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg takes register writes at any time it is idle; ready is always high.
//   i_in takes write, render and frame-end items. Each accepted item of those
//   kinds enters a two-entry command queue; the input stalls only while it is full.
//   o_out gives one colour group per render item, in order, from an output
//   register. Writes, frame ends and the unused kind give no transfer.
//   A render inside the display area is read in the states ST_FIRST and
//   ST_SECOND, set by the four byte reads it needs from the two read ports
//   of the video RAM. Border renders, writes and frame ends need no read.
//   A display render passes the queue, both read states and the stage
//   register on its way to the output register; a border render skips the reads.
//   Reset clears the configuration registers, the flash counter and phase,
//   the queue and the output register; video RAM contents are not cleared.
//   When the receiver stalls, the result holds on o_out, renders stop in the
//   back end and the queue fills before i_in.ready drops.
// ----------------------------------------------------------------------------
module ula_video_pixel_generator import ula_pkg::*; #(
    parameter int VRAM_DEPTH = ULA_VRAM_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ula_cfg_if.sink   i_cfg,
    ula_in_if.sink    i_in,
    ula_out_if.source o_out
);

    logic push;
    t_cmd push_cmd;
    logic queue_full;
    logic pop;
    logic head_valid;
    t_cmd head;

    // Front end: configuration and item classification.
    ula_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_in         (i_in),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // Command queue between the two ends.
    ula_cmd_fifo u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (push_cmd),
        .o_full       (queue_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // Back end: video RAM, flash and colour build.
    ula_back #(
        .VRAM_DEPTH (VRAM_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

/* hdl/ula_ram.sv */
// ----------------------------------------------------------------------------
// ULA generic RAM
// One write port and two read ports with registered, enabled read data.
// ----------------------------------------------------------------------------
module ula_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* hdl/ula_front.sv */
// ----------------------------------------------------------------------------
// ULA front end
// Holds the configuration registers, accepts input items and turns each into
// a command: memory write, frame end, solid fill or display group with its
// video RAM addresses.
// ----------------------------------------------------------------------------
module ula_front import ula_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ula_cfg_if.sink i_cfg,
    ula_in_if.sink  i_in,
    input  logic    i_queue_full,
    output logic    o_push,
    output t_cmd    o_cmd
);

    logic [7:0] r_screen_mode_port;
    logic [7:0] r_scroll_x;
    logic [7:0] r_scroll_y;
    logic       r_fine_scroll_x;
    logic       r_tmx_border_select;

    logic [2:0]         scr_mode;
    logic               is_hicol;
    logic               is_hires;
    logic               is_alt;
    logic [ROW_W-1:0]   srow;
    logic [GROUP_W-1:0] group_off;
    logic [4:0]         col;
    logic [8:0]         scrolled;
    logic [7:0]         er;
    logic [7:0]         sx0;
    logic [4:0]         c0;
    logic [4:0]         c1;
    logic [12:0]        ro_disp;
    logic [12:0]        ro_fold;
    logic [12:0]        disp_off;
    logic               border_row;
    logic               side_border;
    logic               kind_known;

    // Spectrum interleaved row address: Y7..6, Y2..0, Y5..3, then the column.
    function automatic logic [12:0] row_offset(input logic [7:0] r);
        row_offset = {r[7:6], r[2:0], r[5:3], 5'b00000};
    endfunction

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_mode_port  <= 8'd0;
            r_scroll_x          <= 8'd0;
            r_scroll_y          <= 8'd0;
            r_fine_scroll_x     <= 1'b0;
            r_tmx_border_select <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SCREEN_MODE:   r_screen_mode_port  <= i_cfg.data;
                CFG_SCROLL_X:      r_scroll_x          <= i_cfg.data;
                CFG_SCROLL_Y:      r_scroll_y          <= i_cfg.data;
                CFG_FINE_SCROLL_X: r_fine_scroll_x     <= i_cfg.data[0];
                CFG_TMX_BORDER:    r_tmx_border_select <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // Items are taken whenever the queue has room; unused kinds are dropped.
    assign i_in.ready = !i_queue_full;
    assign kind_known = (i_in.kind == KIND_WRITE) || (i_in.kind == KIND_RENDER) ||
                        (i_in.kind == KIND_FRAME);
    assign o_push     = i_in.valid && !i_queue_full && kind_known;

    // Screen mode classification.
    assign scr_mode = r_screen_mode_port[5:3];
    always_comb begin
        is_hicol = 1'b0;
        is_hires = 1'b0;
        is_alt   = 1'b0;
        unique case (scr_mode)
            SCR_STD, SCR_STD_4, SCR_STD_5: begin
            end
            SCR_STD_ALT:              is_alt   = 1'b1;
            SCR_HICOL_0, SCR_HICOL_1: is_hicol = 1'b1;
            SCR_HIRES_0, SCR_HIRES_1: is_hires = 1'b1;
            default: begin
            end
        endcase
    end

    // Screen coordinates of the group.
    assign srow      = i_in.fb_row - ROW_DISP_FIRST;
    assign group_off = i_in.fb_group - GROUP_DISP_FIRST;
    assign col       = group_off[4:0];
    assign ro_disp   = row_offset(srow);
    assign disp_off  = {ro_disp[12:5], col};

    // Vertical scroll folded onto the 192 screen lines.
    assign scrolled = {1'b0, srow} + {1'b0, r_scroll_y};
    always_comb begin
        priority if (scrolled[8:7] == 2'b11) begin
            er = {1'b0, scrolled[6:0]};
        end else if (scrolled[8] || (scrolled[7:6] == 2'b11)) begin
            er = {scrolled[7:6] + 2'd1, scrolled[5:0]};
        end else begin
            er = scrolled[7:0];
        end
    end
    assign ro_fold = row_offset(er);

    // Horizontal scroll: first pixel position and the two byte columns it spans.
    assign sx0 = {col, 3'b000} + r_scroll_x + {7'd0, r_fine_scroll_x};
    assign c0  = sx0[7:3];
    assign c1  = c0 + 5'd1;

    assign border_row  = (i_in.fb_row < ROW_DISP_FIRST) || (i_in.fb_row >= ROW_DISP_END);
    assign side_border = (i_in.fb_group < GROUP_DISP_FIRST) ||
                         (i_in.fb_group >= GROUP_DISP_END);

    // Command build.
    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = OP_FRAME;
        o_cmd.dmode  = DM_ATTR;
        o_cmd.ink    = r_screen_mode_port[2:0];
        o_cmd.paper  = r_screen_mode_port[5:3];
        unique case (i_in.kind)
            KIND_WRITE: begin
                o_cmd.op    = OP_WRITE;
                o_cmd.addr0 = i_in.vram_addr;
                o_cmd.wdata = i_in.vram_data;
            end
            KIND_RENDER: begin
                priority if (border_row) begin
                    o_cmd.op     = OP_FILL;
                    o_cmd.colour = (r_tmx_border_select || is_hires) ?
                                   {1'b0, r_screen_mode_port[5:3]} :
                                   {1'b0, i_in.border_colour};
                end else if (side_border) begin
                    o_cmd.op     = OP_FILL;
                    o_cmd.colour = {1'b0, i_in.border_colour};
                end else if (is_hires) begin
                    o_cmd.op    = OP_DISP;
                    o_cmd.dmode = DM_HIRES;
                    o_cmd.addr0 = {1'b1, disp_off};
                    o_cmd.addr1 = {1'b1, disp_off};
                    o_cmd.addr2 = {1'b1, disp_off};
                    o_cmd.addr3 = {1'b1, disp_off};
                end else if (is_hicol) begin
                    o_cmd.op    = OP_DISP;
                    o_cmd.addr0 = {scr_mode[0], disp_off};
                    o_cmd.addr1 = {1'b1, disp_off};
                    o_cmd.addr2 = {scr_mode[0], disp_off};
                    o_cmd.addr3 = {1'b1, disp_off};
                end else begin
                    o_cmd.op    = OP_DISP;
                    o_cmd.addr0 = {is_alt, ro_fold[12:5], c0};
                    o_cmd.addr1 = {is_alt, 2'b11, 1'b0, er[7:3], c0};
                    o_cmd.addr2 = {is_alt, ro_fold[12:5], c1};
                    o_cmd.addr3 = {is_alt, 2'b11, 1'b0, er[7:3], c1};
                    o_cmd.shift = sx0[2:0];
                end
            end
            default: begin
                o_cmd.op = OP_FRAME;
            end
        endcase
    end

endmodule

/* hdl/ula_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// ULA command queue
// Short register queue between the front end and the back end, with push and
// pop in the same cycle.
// ----------------------------------------------------------------------------
module ula_cmd_fifo import ula_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_head_valid,
    output t_cmd o_head
);

    localparam int QAW = (ULA_QUEUE_DEPTH > 1) ? $clog2(ULA_QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(ULA_QUEUE_DEPTH + 1);
    localparam logic [QAW-1:0] LAST  = QAW'(ULA_QUEUE_DEPTH - 1);
    localparam logic [CW-1:0]  FULLC = CW'(ULA_QUEUE_DEPTH);

    t_cmd           r_entries [ULA_QUEUE_DEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full       = (r_count == FULLC);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_entries[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + QAW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + QAW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* hdl/ula_back.sv */
// ----------------------------------------------------------------------------
// ULA back end
// Carries out queued commands: writes video RAM, steps the flash counter,
// reads pixel and attribute bytes for display groups in the states ST_FIRST and
// ST_SECOND and builds the eight colour indices into the output register.
// ----------------------------------------------------------------------------
module ula_back import ula_pkg::*; #(
    parameter int VRAM_DEPTH = ULA_VRAM_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_cmd      i_head,
    output logic      o_pop,
    ula_out_if.source o_out
);

    localparam int VRAM_AW = $clog2(VRAM_DEPTH);

    // Read issue sequencer of a display group.
    typedef enum logic [1:0] {
        ST_FIRST  = 2'b01,
        ST_SECOND = 2'b10
    } t_issue_state;

    // Group waiting for its last bytes and its colour build.
    typedef struct packed {
        logic                is_fill;
        t_dmode              dmode;
        logic [2:0]          shift;
        logic [COLOUR_W-1:0] colour;
        logic [2:0]          ink;
        logic [2:0]          paper;
        logic                flash;
    } t_s1;

    t_issue_state r_state;
    t_issue_state n_state;
    logic         r_s1_valid;
    t_s1          r_s1;
    logic [3:0]   r_flash_count;
    logic         r_flash_phase;
    logic [3:0]   n_flash_count;
    logic [7:0]   r_hold_pix;
    logic [7:0]   r_hold_attr;
    logic         r_out_valid;
    logic [PIXEL_W-1:0] r_out_data;

    logic               s1_move;
    logic               s1_free;
    logic               load_s1;
    logic               frame_step;
    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  raddr_a;
    logic [ADDR_W-1:0]  raddr_b;
    logic [7:0]         rd_a;
    logic [7:0]         rd_b;
    logic [15:0]        pix_pair;
    logic [3:0]         pos;
    logic               pix_on;
    logic [7:0]         attr;
    logic [2:0]         lane_ink;
    logic [2:0]         lane_paper;
    logic [COLOUR_W-1:0] lane_colour;
    logic [PIXEL_W-1:0] word;

    // Stage hand-off: the stage leaves when the output register is free.
    assign s1_move = r_s1_valid && (!r_out_valid || o_out.ready);
    assign s1_free = !r_s1_valid || s1_move;

    // Command issue.
    always_comb begin
        o_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        load_s1    = 1'b0;
        frame_step = 1'b0;
        n_state    = r_state;
        if (i_head_valid) begin
            unique case (i_head.op)
                OP_WRITE: begin
                    o_pop  = 1'b1;
                    ram_we = 1'b1;
                end
                OP_FRAME: begin
                    o_pop      = 1'b1;
                    frame_step = 1'b1;
                end
                OP_FILL: begin
                    if (s1_free) begin
                        o_pop   = 1'b1;
                        load_s1 = 1'b1;
                    end
                end
                OP_DISP: begin
                    unique case (r_state)
                        ST_FIRST: begin
                            if (s1_free) begin
                                ram_re  = 1'b1;
                                n_state = ST_SECOND;
                            end
                        end
                        ST_SECOND: begin
                            if (s1_free) begin
                                ram_re  = 1'b1;
                                o_pop   = 1'b1;
                                load_s1 = 1'b1;
                                n_state = ST_FIRST;
                            end
                        end
                        default: n_state = ST_FIRST;
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    assign raddr_a = (r_state == ST_SECOND) ? i_head.addr2 : i_head.addr0;
    assign raddr_b = (r_state == ST_SECOND) ? i_head.addr3 : i_head.addr1;

    ula_ram #(
        .WIDTH (DATA_W),
        .DEPTH (VRAM_DEPTH)
    ) u_vram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (i_head.addr0[VRAM_AW-1:0]),
        .i_wdata   (i_head.wdata),
        .i_re      (ram_re),
        .i_raddr_a (raddr_a[VRAM_AW-1:0]),
        .i_raddr_b (raddr_b[VRAM_AW-1:0]),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Flash counter: the phase toggles when the counter wraps.
    assign n_flash_count = r_flash_count + 4'd1;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_FIRST;
            r_s1_valid    <= 1'b0;
            r_flash_count <= 4'd0;
            r_flash_phase <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (frame_step) begin
                r_flash_count <= n_flash_count;
                if (n_flash_count == 4'd0) begin
                    r_flash_phase <= !r_flash_phase;
                end
            end
            if (load_s1) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // First byte pair is parked while the second pair is read.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SECOND) begin
            r_hold_pix  <= rd_a;
            r_hold_attr <= rd_b;
        end
        if (load_s1) begin
            r_s1.is_fill <= (i_head.op == OP_FILL);
            r_s1.dmode   <= i_head.dmode;
            r_s1.shift   <= i_head.shift;
            r_s1.colour  <= i_head.colour;
            r_s1.ink     <= i_head.ink;
            r_s1.paper   <= i_head.paper;
            r_s1.flash   <= r_flash_phase;
        end
        if (s1_move) begin
            r_out_data <= word;
        end
    end

    // Colour build: pixel i comes from bit (shift + i) of the two bytes.
    assign pix_pair = {r_hold_pix, rd_a};
    always_comb begin
        word        = '0;
        pos         = '0;
        pix_on      = 1'b0;
        attr        = '0;
        lane_ink    = '0;
        lane_paper  = '0;
        lane_colour = '0;
        for (int i = 0; i < 8; i++) begin
            pos        = {1'b0, r_s1.shift} + 4'(i);
            pix_on     = pix_pair[4'd15 - pos];
            attr       = pos[3] ? rd_b : r_hold_attr;
            lane_ink   = attr[2:0];
            lane_paper = attr[5:3];
            if (attr[7] && r_s1.flash) begin
                lane_ink   = attr[5:3];
                lane_paper = attr[2:0];
            end
            priority if (r_s1.is_fill) begin
                lane_colour = r_s1.colour;
            end else if (r_s1.dmode == DM_HIRES) begin
                lane_colour = {1'b0, pix_on ? r_s1.ink : r_s1.paper};
            end else begin
                lane_colour = {attr[6], pix_on ? lane_ink : lane_paper};
            end
            word[4*(7-i) +: 4] = lane_colour;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.pixel_group = r_out_data;

endmodule
